### rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// Shadow type tag checker package
// Shared types, request and status codes, and tag constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int unsigned SHADOW_DEPTH_DEF = 65536;
  localparam int unsigned MAX_LEN_DEF      = 4096;

  // Widths wide enough for the largest shadow depth the block supports.
  localparam int unsigned PA_W  = 24;
  localparam int unsigned N_W   = 25;
  localparam int unsigned SUM_W = 28;

  localparam logic [7:0] TAG_TAIL    = 8'hFE;
  localparam logic [7:0] TAG_UNTYPED = 8'hFF;
  localparam logic [7:0] TAG_UNINIT  = 8'h00;

  typedef enum logic [2:0] {
    REQ_STORE  = 3'd0,
    REQ_INIT   = 3'd1,
    REQ_UNINIT = 3'd2,
    REQ_COPY   = 3'd3,
    REQ_REPL   = 3'd4,
    REQ_CHECK  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_MIDOBJ      = 3'd2,
    ST_BADTAIL     = 3'd3,
    ST_ADOPT       = 3'd4,
    ST_ADOPT_TYPED = 3'd5,
    ST_RANGE       = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_FILL,
    CMD_COPY,
    CMD_CHECK,
    CMD_RANGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PA_W-1:0]  dst;
    logic [PA_W-1:0]  src;
    logic [N_W-1:0]   n;
    logic [7:0]       tag_first;
    logic [7:0]       tag_rest;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  found;
    logic [11:0] off;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FILL,
    B_RD,
    B_COPY,
    B_CHK,
    B_DONE
  } bstate_t;

endpackage

`default_nettype wire

### rtl/core/shadow_type_tag_checker_unit.sv
// ----------------------------------------------------------------------------
// Shadow type tag checker
// Byte-wide shadow tag store with typed store, fill, copy, replicate and check.
// ----------------------------------------------------------------------------
// After reset the unit clears its SHADOW_DEPTH-entry tag memory, one entry a
// cycle, and holds in_stall high until the clear is done. Each request then
// passes through the front end (length times count, then range check and
// classification) and waits in a two-entry queue for the tag engine, which
// owns the single tag memory. The engine dispatches each command, works it
// byte by byte and then hands over the result: store type, init and uninit
// write each byte; copy, replicate over length*(rep_count-1) bytes, and check
// read each byte from memory, then write or compare it; check stops at a
// mismatching first byte or at the first bad tail byte. Out of range requests
// go from dispatch straight to the result and leave the store unchanged. Each
// request gives exactly one result.
`timescale 1ns / 1ps
`default_nettype none

module shadow_type_tag_checker_unit #(
  parameter int unsigned SHADOW_DEPTH = stt_pkg::SHADOW_DEPTH_DEF,
  parameter int unsigned MAX_LEN      = stt_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_source_address,
  input  wire logic [12:0] in_length,
  input  wire logic [12:0] in_rep_count,
  input  wire logic [7:0]  in_type_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_found_tag,
  output logic [11:0]      out_bad_offset
);

  logic          clearing;
  logic          q_push, q_full, q_pop, q_empty;
  stt_pkg::cmd_t q_cmd, q_head;

  stt_front #(
    .SHADOW_DEPTH (SHADOW_DEPTH),
    .MAX_LEN      (MAX_LEN)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_address        (in_address),
    .in_source_address (in_source_address),
    .in_length         (in_length),
    .in_rep_count      (in_rep_count),
    .in_type_tag       (in_type_tag),
    .clearing          (clearing),
    .q_push            (q_push),
    .q_cmd             (q_cmd),
    .q_full            (q_full)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_head)
  );

  stt_back #(
    .SHADOW_DEPTH (SHADOW_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found_tag  (out_found_tag),
    .out_bad_offset (out_bad_offset)
  );

  // No request may enter while the tag memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_stall)
    else $error("request accepted during clearing pass");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

### rtl/core/stt_front.sv
// ----------------------------------------------------------------------------
// Shadow type tag checker front end
// Takes requests, checks their ranges and turns them into engine commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_front #(
  parameter int unsigned SHADOW_DEPTH = stt_pkg::SHADOW_DEPTH_DEF,
  parameter int unsigned MAX_LEN      = stt_pkg::MAX_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_req_type,
  input  wire logic [15:0]   in_address,
  input  wire logic [15:0]   in_source_address,
  input  wire logic [12:0]   in_length,
  input  wire logic [12:0]   in_rep_count,
  input  wire logic [7:0]    in_type_tag,
  input  wire logic          clearing,
  output logic               q_push,
  output stt_pkg::cmd_t      q_cmd,
  input  wire logic          q_full
);

  localparam int unsigned SW = stt_pkg::SUM_W;
  localparam logic [SW-1:0] DEPTH_W = SW'(SHADOW_DEPTH);
  localparam logic [SW-1:0] MAXL_W  = SW'(MAX_LEN);

  stt_pkg::fstate_t state_r, state_nxt;
  logic [2:0]  req_r;
  logic [15:0] addr_r, src_r;
  logic [12:0] len_r, cnt_r;
  logic [7:0]  tag_r;
  logic [25:0] prod_r;

  logic [SW-1:0] len_w, cnt_w, addr_w, src_w, prod_w;
  logic          len_bad, cnt_bad, dst_ovf, src_ovf, rep_ovf, bad;
  logic          accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stt_pkg::F_IDLE: if (accept) state_nxt = stt_pkg::F_MUL;
      stt_pkg::F_MUL:  state_nxt = stt_pkg::F_PUSH;
      stt_pkg::F_PUSH: if (!q_full) state_nxt = stt_pkg::F_IDLE;
      default:         state_nxt = stt_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    case (state_r)
      stt_pkg::F_IDLE: in_stall = clearing;
      stt_pkg::F_PUSH: q_push = !q_full;
      default: begin
        in_stall = 1'b1;
        q_push   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stt_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      addr_r <= in_address;
      src_r  <= in_source_address;
      len_r  <= in_length;
      cnt_r  <= in_rep_count;
      tag_r  <= in_type_tag;
    end
    if (state_r == stt_pkg::F_MUL) begin
      prod_r <= len_r * cnt_r;
    end
  end

  // Range checks on the registered request and product.
  always_comb begin
    len_w   = SW'(len_r);
    cnt_w   = SW'(cnt_r);
    addr_w  = SW'(addr_r);
    src_w   = SW'(src_r);
    prod_w  = SW'(prod_r);
    len_bad = (len_r == 13'd0) || (len_w > MAXL_W);
    cnt_bad = (cnt_r == 13'd0) || (cnt_w > MAXL_W);
    dst_ovf = (addr_w + len_w) > DEPTH_W;
    src_ovf = (src_w + len_w) > DEPTH_W;
    rep_ovf = (addr_w + prod_w) > DEPTH_W;
  end

  always_comb begin
    bad             = len_bad || dst_ovf;
    q_cmd.kind      = stt_pkg::CMD_FILL;
    q_cmd.dst       = stt_pkg::PA_W'(addr_r);
    q_cmd.src       = stt_pkg::PA_W'(src_r);
    q_cmd.n         = stt_pkg::N_W'(len_r);
    q_cmd.tag_first = tag_r;
    q_cmd.tag_rest  = stt_pkg::TAG_TAIL;
    case (stt_pkg::req_t'(req_r))
      stt_pkg::REQ_STORE: begin
        q_cmd.kind = stt_pkg::CMD_FILL;
      end
      stt_pkg::REQ_INIT: begin
        q_cmd.tag_first = stt_pkg::TAG_UNTYPED;
        q_cmd.tag_rest  = stt_pkg::TAG_UNTYPED;
      end
      stt_pkg::REQ_UNINIT: begin
        q_cmd.tag_first = stt_pkg::TAG_UNINIT;
        q_cmd.tag_rest  = stt_pkg::TAG_UNINIT;
      end
      stt_pkg::REQ_COPY: begin
        q_cmd.kind = stt_pkg::CMD_COPY;
        bad        = len_bad || dst_ovf || src_ovf;
      end
      stt_pkg::REQ_REPL: begin
        // Replication is a forward copy from the first element onto the rest.
        q_cmd.kind = stt_pkg::CMD_COPY;
        q_cmd.src  = stt_pkg::PA_W'(addr_r);
        q_cmd.dst  = stt_pkg::PA_W'(addr_w + len_w);
        q_cmd.n    = stt_pkg::N_W'(prod_w - len_w);
        bad        = len_bad || dst_ovf || cnt_bad || rep_ovf;
      end
      stt_pkg::REQ_CHECK: begin
        q_cmd.kind = stt_pkg::CMD_CHECK;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      q_cmd.kind = stt_pkg::CMD_RANGE;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stt_queue.sv
// ----------------------------------------------------------------------------
// Shadow type tag checker command queue
// Two-entry queue that decouples the front end from the tag engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire stt_pkg::cmd_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output stt_pkg::cmd_t       pop_data
);

  stt_pkg::cmd_t entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stt_back.sv
// ----------------------------------------------------------------------------
// Shadow type tag checker engine
// Owns the tag memory, runs fill, copy and check commands byte by byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_back #(
  parameter int unsigned SHADOW_DEPTH = stt_pkg::SHADOW_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire stt_pkg::cmd_t  q_data,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          out_status,
  output logic [7:0]          out_found_tag,
  output logic [11:0]         out_bad_offset
);

  localparam int unsigned AW = $clog2(SHADOW_DEPTH);
  localparam int unsigned NW = stt_pkg::N_W;
  localparam int unsigned PW = stt_pkg::PA_W;

  logic [7:0] mem [SHADOW_DEPTH];
  logic [7:0] rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  stt_pkg::bstate_t state_r, state_nxt;
  stt_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [NW-1:0]    idx_r, idx_nxt;
  logic             adopt_r, adopt_nxt;
  stt_pkg::result_t res_r, res_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  stt_pkg::result_t out_r, out_nxt;

  logic [PW-1:0] dst_idx, src_idx;
  logic          last, out_free, first_stop, tail_bad;

  assign dst_idx    = cmd_r.dst + PW'(idx_r);
  assign src_idx    = cmd_r.src + PW'(idx_r);
  assign last       = (NW'(idx_r + 1'b1) == cmd_r.n);
  assign out_free   = !out_valid_r || !out_stall;
  // The first byte ends a check when it is neither the expected type nor untyped.
  assign first_stop = (idx_r == '0) && (rd_q != cmd_r.tag_first)
                      && (rd_q != stt_pkg::TAG_UNTYPED);
  assign tail_bad   = (idx_r != '0) && !adopt_r && (rd_q != stt_pkg::TAG_TAIL);

  assign clearing       = (state_r == stt_pkg::B_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_found_tag  = out_r.found;
  assign out_bad_offset = out_r.off;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stt_pkg::B_CLEAR: begin
        if (clr_r == AW'(SHADOW_DEPTH - 1)) state_nxt = stt_pkg::B_IDLE;
      end
      stt_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_data.kind)
            stt_pkg::CMD_FILL:  state_nxt = (q_data.n == '0) ? stt_pkg::B_DONE
                                                             : stt_pkg::B_FILL;
            stt_pkg::CMD_COPY:  state_nxt = (q_data.n == '0) ? stt_pkg::B_DONE
                                                             : stt_pkg::B_RD;
            stt_pkg::CMD_CHECK: state_nxt = stt_pkg::B_RD;
            default:            state_nxt = stt_pkg::B_DONE;
          endcase
        end
      end
      stt_pkg::B_FILL: if (last) state_nxt = stt_pkg::B_DONE;
      stt_pkg::B_RD: begin
        state_nxt = (cmd_r.kind == stt_pkg::CMD_COPY) ? stt_pkg::B_COPY : stt_pkg::B_CHK;
      end
      stt_pkg::B_COPY: state_nxt = last ? stt_pkg::B_DONE : stt_pkg::B_RD;
      stt_pkg::B_CHK: begin
        state_nxt = (first_stop || tail_bad || last) ? stt_pkg::B_DONE : stt_pkg::B_RD;
      end
      stt_pkg::B_DONE: if (out_free) state_nxt = stt_pkg::B_IDLE;
      default: state_nxt = stt_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    we            = 1'b0;
    waddr         = dst_idx[AW-1:0];
    wdata         = cmd_r.tag_rest;
    raddr         = dst_idx[AW-1:0];
    q_pop         = 1'b0;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    adopt_nxt     = adopt_r;
    res_nxt       = res_r;
    clr_nxt       = clr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      stt_pkg::B_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = stt_pkg::TAG_UNINIT;
        clr_nxt = clr_r + 1'b1;
      end
      stt_pkg::B_IDLE: begin
        q_pop          = !q_empty;
        cmd_nxt        = q_data;
        idx_nxt        = '0;
        adopt_nxt      = 1'b0;
        res_nxt.status = (q_data.kind == stt_pkg::CMD_RANGE) ? stt_pkg::ST_RANGE
                                                              : stt_pkg::ST_OK;
        res_nxt.found  = '0;
        res_nxt.off    = '0;
      end
      stt_pkg::B_FILL: begin
        we      = 1'b1;
        wdata   = (idx_r == '0) ? cmd_r.tag_first : cmd_r.tag_rest;
        idx_nxt = idx_r + 1'b1;
      end
      stt_pkg::B_RD: begin
        raddr = (cmd_r.kind == stt_pkg::CMD_COPY) ? src_idx[AW-1:0] : dst_idx[AW-1:0];
      end
      stt_pkg::B_COPY: begin
        we      = 1'b1;
        wdata   = rd_q;
        idx_nxt = idx_r + 1'b1;
      end
      stt_pkg::B_CHK: begin
        if (idx_r == '0) begin
          if (rd_q == stt_pkg::TAG_TAIL && rd_q != cmd_r.tag_first) begin
            res_nxt.status = stt_pkg::ST_MIDOBJ;
            res_nxt.found  = rd_q;
          end else if (first_stop) begin
            res_nxt.status = stt_pkg::ST_MISMATCH;
            res_nxt.found  = rd_q;
          end else if (rd_q != cmd_r.tag_first) begin
            // Untyped span: adopt the load's type while scanning the rest.
            res_nxt.status = stt_pkg::ST_ADOPT;
            adopt_nxt      = 1'b1;
            we             = 1'b1;
            wdata          = cmd_r.tag_first;
            idx_nxt        = idx_r + 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (adopt_r) begin
          we      = 1'b1;
          wdata   = stt_pkg::TAG_TAIL;
          idx_nxt = idx_r + 1'b1;
          if (rd_q != stt_pkg::TAG_UNTYPED && res_r.status == stt_pkg::ST_ADOPT) begin
            res_nxt.status = stt_pkg::ST_ADOPT_TYPED;
            res_nxt.found  = rd_q;
            res_nxt.off    = idx_r[11:0];
          end
        end else if (tail_bad) begin
          res_nxt.status = stt_pkg::ST_BADTAIL;
          res_nxt.found  = rd_q;
          res_nxt.off    = idx_r[11:0];
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      stt_pkg::B_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stt_pkg::B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    adopt_r <= adopt_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

endmodule

`default_nettype wire

### sim/shadow_type_tag_checker_unit_test.sv
// ----------------------------------------------------------------------------
// Shadow type tag checker testbench
// Drives typed stores, fills, copies, replicates and checked loads through
// the request channel, predicts every status from a private copy of the tag
// store and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shadow_type_tag_checker_unit_test;
  import stt_pkg::*;

  localparam int DEPTH       = 65536;
  localparam int LEN_LIMIT   = 4096;
  localparam int IDLE_LIMIT  = 400000;
  localparam int N_RANDOM    = 1075;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [15:0] in_address;
  logic [15:0] in_source_address;
  logic [12:0] in_length;
  logic [12:0] in_rep_count;
  logic [7:0]  in_type_tag;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [7:0]  out_found_tag;
  logic [11:0] out_bad_offset;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [15:0] src;
    logic [12:0] len;
    logic [12:0] cnt;
    logic [7:0]  tag;
    bit          known;
    status_t     st;
    logic [7:0]  found;
    logic [11:0] off;
  } request_row_t;

  logic [7:0] shadow_tags [0:DEPTH-1];
  result_t    pending_status [$];
  int         mismatches;
  int         requests_sent;
  int         results_seen;
  int         idle_cycles;
  int         status_hits [0:7];
  bit         held_off;

  shadow_type_tag_checker_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_address        (in_address),
    .in_source_address (in_source_address),
    .in_length         (in_length),
    .in_rep_count      (in_rep_count),
    .in_type_tag       (in_type_tag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_tag     (out_found_tag),
    .out_bad_offset    (out_bad_offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the local tag store and returns its status.
  function automatic result_t apply_request(logic [2:0] kind, int addr, int src, int len,
                                            int cnt, logic [7:0] tag);
    result_t    res;
    logic [7:0] first;
    res.status = ST_OK;
    res.found  = TAG_UNINIT;
    res.off    = '0;
    if (kind > REQ_CHECK || len == 0 || len > LEN_LIMIT || addr + len > DEPTH) begin
      res.status = ST_RANGE;
    end else if (kind == REQ_COPY && src + len > DEPTH) begin
      res.status = ST_RANGE;
    end else if (kind == REQ_REPL && (cnt == 0 || cnt > LEN_LIMIT || addr + len * cnt > DEPTH)) begin
      res.status = ST_RANGE;
    end else begin
      case (req_t'(kind))
        REQ_STORE: begin
          shadow_tags[addr] = tag;
          for (int i = 1; i < len; i++) shadow_tags[addr + i] = TAG_TAIL;
        end
        REQ_INIT: begin
          for (int i = 0; i < len; i++) shadow_tags[addr + i] = TAG_UNTYPED;
        end
        REQ_UNINIT: begin
          for (int i = 0; i < len; i++) shadow_tags[addr + i] = TAG_UNINIT;
        end
        REQ_COPY: begin
          // Ascending order, so an overlapping copy smears the source forward.
          for (int i = 0; i < len; i++) shadow_tags[addr + i] = shadow_tags[src + i];
        end
        REQ_REPL: begin
          for (int e = 1; e < cnt; e++)
            for (int i = 0; i < len; i++) shadow_tags[addr + e * len + i] = shadow_tags[addr + i];
        end
        default: begin
          first = shadow_tags[addr];
          if (first == TAG_TAIL && first != tag) begin
            res.status = ST_MIDOBJ;
            res.found  = first;
          end else if (first != tag && first != TAG_UNTYPED) begin
            res.status = ST_MISMATCH;
            res.found  = first;
          end else if (first != tag) begin
            res.status = ST_ADOPT;
            for (int i = 1; i < len; i++) begin
              if (shadow_tags[addr + i] != TAG_UNTYPED) begin
                res.status = ST_ADOPT_TYPED;
                res.found  = shadow_tags[addr + i];
                res.off    = i[11:0];
                break;
              end
            end
            shadow_tags[addr] = tag;
            for (int i = 1; i < len; i++) shadow_tags[addr + i] = TAG_TAIL;
          end else begin
            for (int i = 1; i < len; i++) begin
              if (shadow_tags[addr + i] != TAG_TAIL) begin
                res.status = ST_BADTAIL;
                res.found  = shadow_tags[addr + i];
                res.off    = i[11:0];
                break;
              end
            end
          end
        end
      endcase
    end
    return res;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request, waits for it to be taken and records the prediction.
  task automatic send_request(request_row_t row);
    result_t predicted;
    int      gap;
    in_valid          <= 1'b1;
    in_req_type       <= row.kind;
    in_address        <= row.addr;
    in_source_address <= row.src;
    in_length         <= row.len;
    in_rep_count      <= row.cnt;
    in_type_tag       <= row.tag;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(row.kind, row.addr, row.src, row.len, row.cnt, row.tag);
    if (row.known) begin
      predicted.status = row.st;
      predicted.found  = row.found;
      predicted.off    = row.off;
    end
    pending_status.push_back(predicted);
    requests_sent++;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_row_t make_row(int kind, int addr, int src, int len, int cnt,
                                            int tag);
    request_row_t row;
    row.kind  = kind[2:0];
    row.addr  = addr[15:0];
    row.src   = src[15:0];
    row.len   = len[12:0];
    row.cnt   = cnt[12:0];
    row.tag   = tag[7:0];
    row.known = 1'b0;
    row.st    = ST_OK;
    row.found = '0;
    row.off   = '0;
    return row;
  endfunction

  function automatic request_row_t known_row(int kind, int addr, int src, int len, int cnt,
                                             int tag, status_t st, int found, int off);
    request_row_t row;
    row       = make_row(kind, addr, src, len, cnt, tag);
    row.known = 1'b1;
    row.st    = st;
    row.found = found[7:0];
    row.off   = off[11:0];
    return row;
  endfunction

  // Builds one random request; most of them revisit a small window of the store.
  function automatic request_row_t random_row(ref int last_addr, ref int last_len,
                                              ref logic [7:0] last_tag);
    request_row_t row;
    int r;
    int k;
    int addr;
    int len;
    int cnt;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return make_row($urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 255));
    end
    len  = ($urandom_range(0, 49) == 0) ? $urandom_range(1, LEN_LIMIT) : $urandom_range(1, 12);
    addr = ($urandom_range(0, 19) == 0) ? DEPTH - len - $urandom_range(0, 3)
                                        : $urandom_range(0, 767);
    cnt  = $urandom_range(1, 6);
    k    = $urandom_range(0, 99);
    if (k < 25) begin
      last_addr = addr;
      last_len  = len;
      last_tag  = $urandom_range(1, 253);
      row = make_row(REQ_STORE, addr, 0, len, cnt, last_tag);
    end else if (k < 35) begin
      last_addr = addr;
      last_len  = len;
      row = make_row(REQ_INIT, addr, 0, len, cnt, $urandom_range(0, 255));
    end else if (k < 40) begin
      row = make_row(REQ_UNINIT, addr, 0, len, cnt, $urandom_range(0, 255));
    end else if (k < 48) begin
      row = make_row(REQ_COPY, addr, $urandom_range(0, 767), len, cnt, $urandom_range(0, 255));
    end else if (k < 54) begin
      row = make_row(REQ_REPL, addr, $urandom_range(0, 65535), len, cnt, $urandom_range(0, 255));
    end else if (k < 80) begin
      // Mostly a load of the object just written, sometimes off by a little.
      addr = last_addr + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0);
      len  = last_len + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0);
      row  = make_row(REQ_CHECK, addr, 0, len, cnt,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : last_tag);
    end else begin
      row = make_row(REQ_CHECK, addr, 0, len, cnt, $urandom_range(0, 255));
    end
    return row;
  endfunction

  initial begin
    request_row_t directed [$];
    int           last_addr;
    int           last_len;
    logic [7:0]   last_tag;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = '0;
    in_address        = '0;
    in_source_address = '0;
    in_length         = '0;
    in_rep_count      = '0;
    in_type_tag       = '0;
    mismatches        = 0;
    requests_sent     = 0;
    results_seen      = 0;
    last_addr         = 0;
    last_len          = 1;
    last_tag          = 8'd1;
    foreach (shadow_tags[i]) shadow_tags[i] = TAG_UNINIT;
    foreach (status_hits[i]) status_hits[i] = 0;

    directed.push_back(known_row(REQ_CHECK, 0, 0, 1, 1, 5, ST_MISMATCH, 0, 0));
    directed.push_back(known_row(6, 0, 0, 1, 1, 0, ST_RANGE, 0, 0));
    directed.push_back(known_row(7, 65535, 65535, 8191, 8191, 255, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_STORE, 10, 0, 0, 1, 3, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_INIT, 10, 0, 4097, 1, 3, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_STORE, 65535, 0, 2, 1, 3, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_COPY, 0, 65535, 2, 1, 0, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_REPL, 0, 0, 4, 0, 0, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_REPL, 0, 0, 1, 4097, 0, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_REPL, 0, 0, 4096, 17, 0, ST_RANGE, 0, 0));
    directed.push_back(known_row(REQ_STORE, 100, 0, 4, 1, 7, ST_OK, 0, 0));
    directed.push_back(known_row(REQ_CHECK, 100, 0, 4, 1, 7, ST_OK, 0, 0));
    directed.push_back(known_row(REQ_CHECK, 101, 0, 2, 1, 7, ST_MIDOBJ, 8'hFE, 0));
    directed.push_back(known_row(REQ_CHECK, 100, 0, 5, 1, 7, ST_BADTAIL, 0, 4));
    directed.push_back(known_row(REQ_INIT, 200, 0, 8, 1, 0, ST_OK, 0, 0));
    directed.push_back(known_row(REQ_CHECK, 200, 0, 8, 1, 9, ST_ADOPT, 0, 0));
    directed.push_back(known_row(REQ_INIT, 300, 0, 4, 1, 0, ST_OK, 0, 0));
    directed.push_back(known_row(REQ_STORE, 302, 0, 1, 1, 3, ST_OK, 0, 0));
    directed.push_back(known_row(REQ_CHECK, 300, 0, 4, 1, 9, ST_ADOPT_TYPED, 3, 2));
    directed.push_back(make_row(REQ_COPY, 400, 100, 4, 1, 0));
    directed.push_back(make_row(REQ_COPY, 101, 100, 8, 1, 0));
    directed.push_back(make_row(REQ_REPL, 400, 0, 4, 3, 0));
    directed.push_back(make_row(REQ_STORE, 65535, 0, 1, 1, 255));
    directed.push_back(make_row(REQ_CHECK, 65535, 0, 1, 1, 0));
    directed.push_back(make_row(REQ_UNINIT, 61440, 0, 4096, 1, 0));
    directed.push_back(make_row(REQ_REPL, 0, 0, 16, 4096, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i]);
    for (int n = 0; n < N_RANDOM; n++) send_request(random_row(last_addr, last_len, last_tag));
    in_valid <= 1'b0;

    wait (pending_status.size() == 0);
    repeat (50) @(posedge clk);
    $display("Ran %0d requests: %0d ok, %0d mismatch, %0d mid-object, %0d bad tail,",
             requests_sent, status_hits[ST_OK], status_hits[ST_MISMATCH],
             status_hits[ST_MIDOBJ], status_hits[ST_BADTAIL]);
    $display("  %0d adopted, %0d adopted over typed bytes, %0d out of range; %0d errors.",
             status_hits[ST_ADOPT], status_hits[ST_ADOPT_TYPED], status_hits[ST_RANGE],
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side back-pressure, with one long hold-off once traffic is flowing.
  initial begin
    int hold;
    out_stall = 1'b1;
    held_off  = 1'b0;
    @(posedge clk);
    forever begin
      if (!held_off && requests_sent > 300) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      hold = gap_cycles();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d tag %02h offset %0d",
                   out_status, out_found_tag, out_bad_offset);
      end else begin
        want = pending_status.pop_front();
        status_hits[want.status]++;
        if (out_status !== want.status || out_found_tag !== want.found ||
            out_bad_offset !== want.off) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected status %0d tag %02h offset %0d, got %0d %02h %0d",
                     results_seen, want.status, want.found, want.off,
                     out_status, out_found_tag, out_bad_offset);
        end
      end
    end
  end

  // The count restarts whenever either channel moves a request or a result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d idle cycles with %0d results outstanding.",
               idle_cycles, pending_status.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule

### shadow_type_tag_checker_unit.f
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/shadow_type_tag_checker_unit.sv
sim/shadow_type_tag_checker_unit_test.sv
